/* rtl/bslp_pkg.sv */
// Package for the button short/long press classifier.
// Holds the transfer structs, configuration register indexes, event codes and widths.
// No dependencies; imported by bslp_front, bslp_btn, bslp_back and the top level.
package bslp_pkg;

    localparam int NUM_BUTTONS  = 3;
    localparam int DEBOUNCE_W   = 16;
    localparam int LONG_W       = 16;
    localparam int CONFIRM_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int EVENT_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM  = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1000;
    localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET  = 8'd5;

    localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EVENT_W-1:0] EV_UP_SHORT   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_UP_LONG    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_OK_SHORT   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_OK_LONG    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_DOWN_SHORT = 3'd5;
    localparam logic [EVENT_W-1:0] EV_DOWN_LONG  = 3'd6;

    localparam logic [EVENT_W-1:0] SHORT_CODE [NUM_BUTTONS] =
        '{EV_UP_SHORT, EV_OK_SHORT, EV_DOWN_SHORT};
    localparam logic [EVENT_W-1:0] LONG_CODE [NUM_BUTTONS] =
        '{EV_UP_LONG, EV_OK_LONG, EV_DOWN_LONG};

    typedef struct packed {
        logic mode;
        logic up_level;
        logic ok_level;
        logic down_level;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic               queue_nonempty;
    } t_out_item;

    typedef struct packed {
        logic                   is_pop;
        logic [NUM_BUTTONS-1:0] levels;
    } t_cmd;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [LONG_W-1:0]     long_press_ticks;
        logic [CONFIRM_W-1:0]  release_confirm_ticks;
    } t_cfg;

    typedef struct packed {
        logic long_ev;
        logic short_ev;
    } t_btn_ev;

endpackage

/* rtl/bslp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the event queue storage; depends on nothing.
module bslp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bslp_front.sv */
// Front end: a two-entry command queue that takes input transfers and decodes them.
// Depends on bslp_pkg for the item and command structs.
module bslp_front
    import bslp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_take
);

    logic [1:0] r_cnt, n_cnt;
    logic       r_head, n_head;
    t_cmd       r_slot [2];
    logic       push;
    logic       tail;
    t_cmd       decoded;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign tail        = r_head ^ r_cnt[0];
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_head];

    always_comb begin
        decoded.is_pop = i_item.mode;
        decoded.levels = {i_item.down_level, i_item.ok_level, i_item.up_level};
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        if (i_take) begin
            n_head = ~r_head;
        end
        if (push && !i_take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[tail] <= decoded;
        end
    end

endmodule

/* rtl/bslp_btn.sv */
// One button lane: edge detection, debounce, long-press timer and release confirmation.
// Depends on bslp_pkg for the configuration and event structs.
module bslp_btn
    import bslp_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_level,
    input  t_cfg    i_cfg,
    output t_btn_ev o_ev
);

    localparam int CMPW = (COUNTER_WIDTH > DEBOUNCE_W) ? COUNTER_WIDTH : DEBOUNCE_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [CONFIRM_W-1:0]     RUN_MAX = '1;

    logic                     r_prev, n_prev;
    logic                     r_pressed, n_pressed;
    logic                     r_long_fired, n_long_fired;
    logic [COUNTER_WIDTH-1:0] r_cnt, n_cnt;
    logic [CONFIRM_W-1:0]     r_run, n_run;
    logic [COUNTER_WIDTH-1:0] cnt_inc;
    logic [CONFIRM_W-1:0]     run_inc;

    assign cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_prev       = r_prev;
        n_pressed    = r_pressed;
        n_long_fired = r_long_fired;
        n_cnt        = r_cnt;
        n_run        = r_run;
        run_inc      = r_run;
        o_ev         = '0;
        if (i_en) begin
            n_prev = i_level;
            n_cnt  = cnt_inc;
            if (r_prev && !i_level && !r_pressed &&
                CMPW'(cnt_inc) >= CMPW'(i_cfg.debounce_ticks)) begin
                n_pressed    = 1'b1;
                n_long_fired = 1'b0;
                n_cnt        = '0;
                n_run        = '0;
            end
            if (n_pressed) begin
                if (!n_long_fired && CMPW'(n_cnt) >= CMPW'(i_cfg.long_press_ticks)) begin
                    n_long_fired = 1'b1;
                    o_ev.long_ev = 1'b1;
                end
                if (i_level) begin
                    run_inc = (n_run == RUN_MAX) ? n_run : n_run + 1'b1;
                    if (run_inc >= i_cfg.release_confirm_ticks) begin
                        o_ev.short_ev = !n_long_fired;
                        n_pressed     = 1'b0;
                        n_run         = '0;
                    end else begin
                        n_run = run_inc;
                    end
                end else begin
                    n_run = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 1'b1;
            r_pressed    <= 1'b0;
            r_long_fired <= 1'b0;
            r_cnt        <= '0;
            r_run        <= '0;
        end else begin
            r_prev       <= n_prev;
            r_pressed    <= n_pressed;
            r_long_fired <= n_long_fired;
            r_cnt        <= n_cnt;
            r_run        <= n_run;
        end
    end

endmodule

/* rtl/bslp_back.sv */
// Back end: configuration registers, the three button lanes, the event queue and the result register.
// Depends on bslp_pkg, bslp_btn and bslp_ram.
module bslp_back
    import bslp_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 8,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_take,
    output logic                   o_valid,
    output t_out_item              o_item,
    input  logic                   i_stall
);

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = CNW + 2;
    localparam logic [QPW-1:0] PTR_LAST = QPW'(QUEUE_DEPTH - 1);

    t_cfg                r_cfg;
    logic [1:0]          r_pend_cnt, n_pend_cnt;
    logic [EVENT_W-1:0]  r_pend_code [2];
    logic [EVENT_W-1:0]  n_pend_code [2];
    logic [QPW-1:0]      r_wptr, n_wptr;
    logic [QPW-1:0]      r_rptr, n_rptr;
    logic [CNW-1:0]      r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic                r_out_nonempty, n_out_nonempty;

    logic                exec;
    logic                exec_tick;
    logic                pop_hit;
    t_btn_ev             btn_ev [NUM_BUTTONS];
    logic [EVENT_W-1:0]  list [NUM_BUTTONS];
    logic [1:0]          n_acc;
    logic [SW-1:0]       taken;
    logic                ram_we;
    logic [EVENT_W-1:0]  ram_wdata;
    logic [EVENT_W-1:0]  ram_rdata;

    assign exec      = i_cmd_valid && (r_pend_cnt == 2'd0) && (!r_out_valid || !i_stall);
    assign exec_tick = exec && !i_cmd.is_pop;
    assign pop_hit   = exec && i_cmd.is_pop && (r_count != '0);
    assign o_take    = exec;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        bslp_btn #(
            .COUNTER_WIDTH(COUNTER_WIDTH)
        ) u_btn (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (exec_tick),
            .i_level(i_cmd.levels[g]),
            .i_cfg  (r_cfg),
            .o_ev   (btn_ev[g])
        );
    end

    // Events are admitted in button order while the queue has room; the rest are dropped.
    always_comb begin
        n_acc = 2'd0;
        taken = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            list[i] = EV_NONE;
        end
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (exec_tick && (btn_ev[i].long_ev || btn_ev[i].short_ev) &&
                (SW'(r_count) + taken) < SW'(QUEUE_DEPTH)) begin
                list[n_acc] = btn_ev[i].long_ev ? LONG_CODE[i] : SHORT_CODE[i];
                n_acc       = n_acc + 2'd1;
                taken       = taken + 1'b1;
            end
        end
    end

    always_comb begin
        ram_we      = 1'b0;
        ram_wdata   = r_pend_code[0];
        n_pend_cnt  = r_pend_cnt;
        n_pend_code = r_pend_code;
        priority if (r_pend_cnt != 2'd0) begin
            ram_we         = 1'b1;
            n_pend_code[0] = r_pend_code[1];
            n_pend_cnt     = r_pend_cnt - 2'd1;
        end else if (exec_tick && n_acc != 2'd0) begin
            ram_we         = 1'b1;
            ram_wdata      = list[0];
            n_pend_code[0] = list[1];
            n_pend_code[1] = list[2];
            n_pend_cnt     = n_acc - 2'd1;
        end
    end

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (ram_we) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (pop_hit) begin
            n_rptr  = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            n_count = r_count - 1'b1;
        end else if (exec_tick) begin
            n_count = r_count + CNW'(n_acc);
        end
    end

    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_hit      = r_out_hit;
        n_out_nonempty = r_out_nonempty;
        if (exec) begin
            n_out_valid    = 1'b1;
            n_out_hit      = pop_hit;
            n_out_nonempty = (n_count != '0);
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    bslp_ram #(
        .WIDTH(EVENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wptr),
        .i_wdata(ram_wdata),
        .i_re   (pop_hit),
        .i_raddr(r_rptr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks        <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks      <= LONG_RESET;
            r_cfg.release_confirm_ticks <= CONFIRM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce_ticks        <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_LONG:     r_cfg.long_press_ticks      <= i_cfg_data[LONG_W-1:0];
                CFG_CONFIRM:  r_cfg.release_confirm_ticks <= i_cfg_data[CONFIRM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt  <= 2'd0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend_cnt  <= n_pend_cnt;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_code    <= n_pend_code;
        r_out_hit      <= n_out_hit;
        r_out_nonempty <= n_out_nonempty;
    end

    assign o_valid               = r_out_valid;
    assign o_item.event_code     = r_out_hit ? ram_rdata : EV_NONE;
    assign o_item.queue_nonempty = r_out_nonempty;

endmodule

/* rtl/button_short_long_press_classifier_core.sv */
// Top level of the button short/long press classifier: front command queue and back end.
// Depends on bslp_pkg, bslp_front and bslp_back.
//
// Each input transfer is either a millisecond tick carrying the three active-low pin levels or
// a pop that removes the oldest queued event; every transfer yields exactly one result transfer.
// The block takes one item per clock cycle unless o_stall holds it. A tick that queues two or three
// events at once holds the next item while the extra events are written, because the event
// memory has a single write port and takes one event per cycle. An unstalled item is registered
// in the two-entry front queue, and when the back end takes it, its result is loaded into the
// output register; a popped code comes from the registered read of the event memory. There is
// no clearing pass after reset. The user must write configuration only while the block is idle;
// the block itself does not enforce this.
module button_short_long_press_classifier_core
    import bslp_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 8,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    input  t_in_item               i_item,
    output logic                   o_stall,
    output logic                   o_valid,
    output t_out_item              o_item,
    input  logic                   i_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    bslp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_take     (cmd_take)
    );

    bslp_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_take     (cmd_take),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_stall    (i_stall)
    );

endmodule
